[hw/rtl/debrf_pkg.sv]
// Shared types, widths and constants for the dual EMA baseline removal filter.
`default_nettype none

package debrf_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 18;
    localparam int DECAY_W   = 16;
    localparam int LIMIT_W   = 15;
    localparam int COUNT_W   = 16;
    localparam int VALUE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 18;

    // Accumulator widths: sum is Q40.8, weight is Q16.16
    localparam int SUM_W    = 48;
    localparam int WEIGHT_W = 32;
    // The weight is at least 1.0 after an update, so the top 15 bits of the
    // quotient sum * 2^16 / weight are always zero.
    localparam int MEAN_W   = 49;

    // Serial step counts and the step counter width
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] MUL_LAST   = 6'd15;  // 16 decay bits
    localparam logic [STEP_W-1:0] DIV_LAST   = 6'd48;  // 49 quotient bits
    localparam logic [STEP_W-1:0] SCALE_LAST = 6'd19;  // 20 bits through the /20

    // Scaling of the mean difference
    localparam int SCALE_IN_W = 20;
    localparam logic [5:0] SCALE_DIVISOR = 6'd20;
    // 20 * 2^15: any difference at or above this cannot land in range
    localparam logic [SCALE_IN_W-1:0] SCALE_LIMIT = 20'd655360;

    // Valid emitted words needed before the buffer counts as ready
    localparam logic [COUNT_W-1:0] FILL_COUNT = 16'd256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_DECAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_DECAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIMEOUT = 3'd4;

    // Register reset values
    localparam logic [DECAY_W-1:0]  RST_SHORT_DECAY   = 16'd58137;
    localparam logic [DECAY_W-1:0]  RST_LONG_DECAY    = 16'd63984;
    localparam logic [SAMPLE_W-1:0] RST_SIG_THRESHOLD = 18'd10000;
    localparam logic [LIMIT_W-1:0]  RST_OUTPUT_LIMIT  = 15'd12800;
    localparam logic [COUNT_W-1:0]  RST_START_TIMEOUT = 16'd2500;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DIV,
        ST_DIFF,
        ST_SCALE,
        ST_DONE
    } state_t;

    // Sequencer commands to an averaging lane
    typedef struct packed {
        logic clear;     // return sum and weight to zero
        logic load_mul;  // start the decay multiply
        logic mul_step;  // one decay bit
        logic update;    // commit sum and weight, load the divider
        logic div_step;  // one quotient bit
    } lane_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/debrf_if.sv]
// Handshake channels for sensor samples and filter results.
`default_nettype none

interface debrf_sample_if;
    logic                          valid;
    logic                          ready;
    logic [debrf_pkg::SAMPLE_W-1:0] sensor_sample;

    modport source (output valid, output sensor_sample, input ready);
    modport sink   (input valid, input sensor_sample, output ready);
endinterface

interface debrf_result_if;
    logic                                valid;
    logic                                ready;
    logic                                sample_valid;
    logic signed [debrf_pkg::VALUE_W-1:0] filtered_value;
    logic                                sensor_active;
    logic                                buffer_ready;
    logic                                start_fault;

    modport source (output valid, output sample_valid, output filtered_value,
                    output sensor_active, output buffer_ready, output start_fault,
                    input ready);
    modport sink   (input valid, input sample_valid, input filtered_value,
                    input sensor_active, input buffer_ready, input start_fault,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/dual_ema_baseline_removal_filter.sv]
// Top level of the dual EMA baseline removal filter: sequencer, start detector and scaling.
`default_nettype none

// One sensor sample in, one result word out, always. Before the sensor has
// started (first sample above 1) idle samples are counted; once the count
// passes start_timeout the block reports start_fault and returns to its reset
// state, registers apart. A sample above signal_threshold updates a short and
// a long weight-normalised exponential average; the short mean minus the long
// mean, divided by 20, is emitted as signed Q8.8 when its magnitude is at most
// output_limit, otherwise sample_valid is low and filtered_value is zero.
// Steps: a filtered sample runs from acceptance through the bit-serial decay
// multiply, the update, the bit-serial mean divide, the difference, the
// bit-serial divide by 20 and the result back to idle; a sample that is not
// filtered goes from acceptance straight to the result and back to idle.
// Both averages run side by side in their own lanes. One sample is in work at
// a time and is held in a register once accepted; the result sits in an
// output register, so a new sample may be accepted while the previous word
// waits to be taken. A word that is still not taken when the next one is
// done holds the block in its last state. Configuration writes belong to
// idle periods.
module dual_ema_baseline_removal_filter (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    debrf_sample_if.sink                              samples,
    debrf_result_if.source                            results,
    input  wire logic                                 cfg_we,
    input  wire logic [debrf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [debrf_pkg::CFG_W-1:0]          cfg_data
);

    localparam int CW = debrf_pkg::COUNT_W;

    // Configuration registers
    logic [debrf_pkg::DECAY_W-1:0]  short_decay_reg;
    logic [debrf_pkg::DECAY_W-1:0]  long_decay_reg;
    logic [debrf_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [debrf_pkg::LIMIT_W-1:0]  limit_reg;
    logic [CW-1:0]                  timeout_reg;

    // Sequencer and block state
    debrf_pkg::state_t              state_reg, state_next;
    logic [debrf_pkg::STEP_W-1:0]   step_reg;
    logic                           started_reg;
    logic                           ready_reg;
    logic [CW-1:0]                  count_reg;
    logic                           fault_reg;
    logic                           filt_reg;
    logic [debrf_pkg::SAMPLE_W-1:0] sample_reg;

    // Scaling datapath
    logic                               neg_reg;
    logic                               big_reg;
    logic [4:0]                         srem_reg;
    logic [debrf_pkg::SCALE_IN_W-1:0]   squo_reg;

    // Output word register
    logic                               res_vld_reg;
    logic                               res_sv_reg;
    logic [debrf_pkg::VALUE_W-1:0]      res_val_reg;
    logic                               res_started_reg;
    logic                               res_ready_reg;
    logic                               res_fault_reg;

    // Combinational signals
    debrf_pkg::lane_ctrl_t          lane_ctrl;
    logic [debrf_pkg::MEAN_W-1:0]   mean_short, mean_long;
    logic                           accept;
    logic                           out_free;
    logic                           done_fire;
    logic                           step_zero;
    logic [debrf_pkg::SAMPLE_W-1:0] s_in;
    logic                           above_one;
    logic [CW-1:0]                  idle_inc;
    logic                           fault_now;
    logic                           filt_now;
    logic [debrf_pkg::MEAN_W:0]     mean_diff, mean_mag;
    logic                           big_now;
    logic [5:0]                     sc_trial, sc_sub;
    logic                           sc_ge;
    logic [debrf_pkg::LIMIT_W-1:0]  q_mag;
    logic                           in_range;
    logic                           valid_now;
    logic [debrf_pkg::VALUE_W-1:0]  value_now;
    logic [CW-1:0]                  fill_inc;
    logic                           ready_now;

    // ------------------------------------------------------------------
    // Configuration port: unknown indexes are ignored
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_decay_reg <= debrf_pkg::RST_SHORT_DECAY;
            long_decay_reg  <= debrf_pkg::RST_LONG_DECAY;
            threshold_reg   <= debrf_pkg::RST_SIG_THRESHOLD;
            limit_reg       <= debrf_pkg::RST_OUTPUT_LIMIT;
            timeout_reg     <= debrf_pkg::RST_START_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                debrf_pkg::REG_SHORT_DECAY:   short_decay_reg <= cfg_data[debrf_pkg::DECAY_W-1:0];
                debrf_pkg::REG_LONG_DECAY:    long_decay_reg  <= cfg_data[debrf_pkg::DECAY_W-1:0];
                debrf_pkg::REG_SIG_THRESHOLD: threshold_reg   <= cfg_data[debrf_pkg::SAMPLE_W-1:0];
                debrf_pkg::REG_OUTPUT_LIMIT:  limit_reg       <= cfg_data[debrf_pkg::LIMIT_W-1:0];
                debrf_pkg::REG_START_TIMEOUT: timeout_reg     <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Start detector and filter decision, evaluated on the accepted word
    // ------------------------------------------------------------------
    always_comb
    begin
        s_in      = samples.sensor_sample;
        above_one = (s_in > 18'd1);
        idle_inc  = (count_reg != '1) ? count_reg + 1'b1 : count_reg;
        // the idle count saturates, so the largest timeout never faults
        fault_now = !started_reg && !above_one && (idle_inc > timeout_reg);
        filt_now  = !fault_now && (s_in > threshold_reg);
    end

    // ------------------------------------------------------------------
    // Scaling: difference of the means, then divide its magnitude by 20
    // ------------------------------------------------------------------
    always_comb
    begin
        mean_diff = {1'b0, mean_short} - {1'b0, mean_long};
        mean_mag  = mean_diff[debrf_pkg::MEAN_W] ? (~mean_diff + 1'b1) : mean_diff;
        // anything at or above 20 * 2^15 is out of range whatever the limit
        big_now   = (mean_mag[debrf_pkg::MEAN_W:debrf_pkg::SCALE_IN_W] != '0) ||
                    (mean_mag[debrf_pkg::SCALE_IN_W-1:0] >= debrf_pkg::SCALE_LIMIT);

        sc_trial  = {srem_reg, squo_reg[debrf_pkg::SCALE_IN_W-1]};
        sc_sub    = sc_trial - debrf_pkg::SCALE_DIVISOR;
        sc_ge     = (sc_trial >= debrf_pkg::SCALE_DIVISOR);

        q_mag     = squo_reg[debrf_pkg::LIMIT_W-1:0];
        in_range  = !big_reg &&
                    (squo_reg[debrf_pkg::SCALE_IN_W-1:debrf_pkg::LIMIT_W] == '0) &&
                    (q_mag <= limit_reg);
        valid_now = filt_reg && in_range;
        value_now = !valid_now ? '0 :
                    neg_reg    ? (~{1'b0, q_mag} + 1'b1) : {1'b0, q_mag};

        // fill counting stops once the buffer is ready
        fill_inc  = (count_reg != '1) ? count_reg + 1'b1 : count_reg;
        ready_now = ready_reg || (valid_now && (fill_inc >= debrf_pkg::FILL_COUNT));
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free  = !res_vld_reg || results.ready;
    assign accept    = samples.valid && samples.ready;
    assign step_zero = (step_reg == '0);
    assign done_fire = (state_reg == debrf_pkg::ST_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            debrf_pkg::ST_IDLE:
            begin
                if (samples.valid)
                    state_next = filt_now ? debrf_pkg::ST_MUL : debrf_pkg::ST_DONE;
            end
            debrf_pkg::ST_MUL:   if (step_zero) state_next = debrf_pkg::ST_UPD;
            debrf_pkg::ST_UPD:   state_next = debrf_pkg::ST_DIV;
            debrf_pkg::ST_DIV:   if (step_zero) state_next = debrf_pkg::ST_DIFF;
            debrf_pkg::ST_DIFF:  state_next = debrf_pkg::ST_SCALE;
            debrf_pkg::ST_SCALE: if (step_zero) state_next = debrf_pkg::ST_DONE;
            debrf_pkg::ST_DONE:  if (out_free) state_next = debrf_pkg::ST_IDLE;
            default:             state_next = debrf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        samples.ready      = (state_reg == debrf_pkg::ST_IDLE);
        lane_ctrl.clear    = accept && fault_now;
        lane_ctrl.load_mul = accept && filt_now;
        lane_ctrl.mul_step = (state_reg == debrf_pkg::ST_MUL);
        lane_ctrl.update   = (state_reg == debrf_pkg::ST_UPD);
        lane_ctrl.div_step = (state_reg == debrf_pkg::ST_DIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= debrf_pkg::ST_IDLE;
            step_reg    <= '0;
            started_reg <= 1'b0;
            ready_reg   <= 1'b0;
            count_reg   <= '0;
            fault_reg   <= 1'b0;
            filt_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // step counter: load on entry to a serial phase, count down in it
            if (accept)
                step_reg <= debrf_pkg::MUL_LAST;
            else if (state_reg == debrf_pkg::ST_UPD)
                step_reg <= debrf_pkg::DIV_LAST;
            else if (state_reg == debrf_pkg::ST_DIFF)
                step_reg <= debrf_pkg::SCALE_LAST;
            else if (!step_zero)
                step_reg <= step_reg - 1'b1;

            if (accept)
            begin
                fault_reg <= fault_now;
                filt_reg  <= filt_now;
                if (fault_now)
                begin
                    // timeout: drop back to the reset state
                    started_reg <= 1'b0;
                    ready_reg   <= 1'b0;
                    count_reg   <= '0;
                end
                else if (!started_reg)
                begin
                    started_reg <= above_one;
                    count_reg   <= above_one ? '0 : idle_inc;
                end
            end
            else if (done_fire && valid_now && !ready_reg)
            begin
                count_reg <= fill_inc;
                ready_reg <= ready_now;
            end
        end
    end

    // Hold the accepted sample for the lane update; the source may move on
    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= s_in;
    end

    // Scaling registers carry payload only
    always_ff @(posedge clk)
    begin
        if (state_reg == debrf_pkg::ST_DIFF)
        begin
            neg_reg  <= mean_diff[debrf_pkg::MEAN_W];
            big_reg  <= big_now;
            srem_reg <= '0;
            squo_reg <= mean_mag[debrf_pkg::SCALE_IN_W-1:0];
        end
        else if (state_reg == debrf_pkg::ST_SCALE)
        begin
            srem_reg <= sc_ge ? sc_sub[4:0] : sc_trial[4:0];
            squo_reg <= {squo_reg[debrf_pkg::SCALE_IN_W-2:0], sc_ge};
        end
    end

    // ------------------------------------------------------------------
    // Averaging lanes
    // ------------------------------------------------------------------
    debrf_ema u_short (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .decay  (short_decay_reg),
        .sample (sample_reg),
        .mean   (mean_short)
    );

    debrf_ema u_long (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .decay  (long_decay_reg),
        .sample (sample_reg),
        .mean   (mean_long)
    );

    // ------------------------------------------------------------------
    // Output word register: hold until taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (done_fire)
            res_vld_reg <= 1'b1;
        else if (results.ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            res_sv_reg      <= valid_now;
            res_val_reg     <= value_now;
            res_started_reg <= started_reg;
            res_ready_reg   <= ready_now;
            res_fault_reg   <= fault_reg;
        end
    end

    assign results.valid          = res_vld_reg;
    assign results.sample_valid   = res_sv_reg;
    assign results.filtered_value = res_val_reg;
    assign results.sensor_active  = res_started_reg;
    assign results.buffer_ready   = res_ready_reg;
    assign results.start_fault    = res_fault_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fault_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.start_fault |->
            !results.sample_valid && !results.sensor_active && !results.buffer_ready)
        else $error("start fault word carries live status");

    a_dropped_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.sample_valid |-> results.filtered_value == '0)
        else $error("dropped word has a nonzero value");

    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg && !(accept && fault_now) |=> ready_reg)
        else $error("buffer ready fell without a start fault");

endmodule

`default_nettype wire

[hw/rtl/debrf_ema.sv]
// One weight-normalised exponential average: serial decay multiply and serial mean divide.
`default_nettype none

module debrf_ema (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire debrf_pkg::lane_ctrl_t              ctrl,
    input  wire logic [debrf_pkg::DECAY_W-1:0]      decay,
    input  wire logic [debrf_pkg::SAMPLE_W-1:0]     sample,
    output logic      [debrf_pkg::MEAN_W-1:0]       mean
);

    localparam int SW = debrf_pkg::SUM_W;
    localparam int WW = debrf_pkg::WEIGHT_W;
    localparam int MW = debrf_pkg::MEAN_W;

    logic [SW-1:0]                  sum_reg;
    logic [WW-1:0]                  weight_reg;
    logic [SW-1:0]                  acc_s_reg, acc_s_next;
    logic [WW-1:0]                  acc_w_reg, acc_w_next;
    logic [debrf_pkg::DECAY_W-1:0]  dec_reg;
    logic [WW-1:0]                  rem_reg, rem_next;
    logic [MW-1:0]                  quo_reg, quo_next;

    logic [SW:0]   mul_s, upd_s;
    logic [WW:0]   mul_w, upd_w;
    logic [SW-1:0] sum_upd;
    logic [WW-1:0] weight_upd;
    logic [WW:0]   trial, trial_sub;
    logic          trial_ge;

    always_comb
    begin
        // acc = (acc + bit * x) >> 1 over the decay bits gives floor(x * decay / 2^16)
        mul_s      = {1'b0, acc_s_reg} + (dec_reg[0] ? {1'b0, sum_reg} : '0);
        mul_w      = {1'b0, acc_w_reg} + (dec_reg[0] ? {1'b0, weight_reg} : '0);
        acc_s_next = mul_s[SW:1];
        acc_w_next = mul_w[WW:1];

        // add the new sample (Q.8) and unit weight, saturate
        upd_s      = {1'b0, acc_s_reg} + {{(SW+1-debrf_pkg::SAMPLE_W-8){1'b0}}, sample, 8'd0};
        upd_w      = {1'b0, acc_w_reg} + {{(WW-16){1'b0}}, 17'h1_0000};
        sum_upd    = upd_s[SW] ? '1 : upd_s[SW-1:0];
        weight_upd = upd_w[WW] ? '1 : upd_w[WW-1:0];

        // restoring divide, one quotient bit per step
        trial     = {rem_reg, quo_reg[MW-1]};
        trial_sub = trial - {1'b0, weight_reg};
        trial_ge  = (trial >= {1'b0, weight_reg});
        rem_next  = trial_ge ? trial_sub[WW-1:0] : trial[WW-1:0];
        quo_next  = {quo_reg[MW-2:0], trial_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            weight_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            sum_reg    <= '0;
            weight_reg <= '0;
        end
        else if (ctrl.update)
        begin
            sum_reg    <= sum_upd;
            weight_reg <= weight_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mul)
        begin
            acc_s_reg <= '0;
            acc_w_reg <= '0;
            dec_reg   <= decay;
        end
        else if (ctrl.mul_step)
        begin
            acc_s_reg <= acc_s_next;
            acc_w_reg <= acc_w_next;
            dec_reg   <= {1'b0, dec_reg[debrf_pkg::DECAY_W-1:1]};
        end

        if (ctrl.update)
        begin
            // numerator is sum << 16; its top 15 bits are below the weight
            rem_reg <= {{(WW-15){1'b0}}, sum_upd[SW-1:SW-15]};
            quo_reg <= {sum_upd[SW-16:0], 16'd0};
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign mean = quo_reg;

endmodule

`default_nettype wire
